@@ rtl/bsfd_pkg.sv @@
package bsfd_pkg;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_FRAME_FLAG    = 2'd0;
	localparam logic [1:0] REG_ESCAPE_CODE   = 2'd1;
	localparam logic [1:0] REG_ESCAPE_OFFSET = 2'd2;

	localparam logic [7:0] FRAME_FLAG_RST    = 8'h7D;
	localparam logic [7:0] ESCAPE_CODE_RST   = 8'h7E;
	localparam logic [7:0] ESCAPE_OFFSET_RST = 8'h20;

	// Result kinds carried on the output tuser.
	localparam logic KIND_PAYLOAD   = 1'b0;
	localparam logic KIND_FRAME_END = 1'b1;

	typedef struct packed {
		logic [7:0] frame_flag;
		logic [7:0] escape_code;
		logic [7:0] escape_offset;
	} cfg_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] payload;
		logic       frame_good;
		logic       last;
	} result_t;

	// What one input byte produces: up to two results, first in res0.
	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} decode_out_t;

endpackage

@@ rtl/byte_stuff_frame_decoder.sv @@
// An accepted input request is registered in the input stage and decoded into the queue.
// Throughput: one input request per cycle while the queue can take two results; each
// byte yields zero, one or two results; the queue hands one out per cycle on m_tready.
// Reset: arst_n clears the deframer state, the input stage and the result queue
// asynchronously and loads the register defaults (flag 0x7D, escape 0x7E, offset 0x20).
module byte_stuff_frame_decoder #(
	parameter int QDEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,

	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // chunk_end

	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload, [8] frame_good, [15:9] zero
	output logic        m_tuser,   // item_kind: 0 payload byte, 1 frame end
	output logic        m_tlast,   // last result caused by one input byte

	// The user makes configuration writes only while idle; the block does not enforce it.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	// The input request is registered first; the decode works from that stage
	// so the deframer logic sees only flops, and the result queue after it
	// decouples the two-results-per-byte bursts from the output handshake.
	logic       s1_valid_q;
	logic [7:0] s1_byte_s1;
	logic       s1_chunk_s1;
	logic       fire;
	logic       room2;
	logic       q_valid;

	bsfd_pkg::cfg_t        cfg_q;
	bsfd_pkg::decode_out_t dec;
	bsfd_pkg::result_t     q_out;

	// Register file; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_flag    <= bsfd_pkg::FRAME_FLAG_RST;
			cfg_q.escape_code   <= bsfd_pkg::ESCAPE_CODE_RST;
			cfg_q.escape_offset <= bsfd_pkg::ESCAPE_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bsfd_pkg::REG_FRAME_FLAG:    cfg_q.frame_flag    <= cfg_data;
				bsfd_pkg::REG_ESCAPE_CODE:   cfg_q.escape_code   <= cfg_data;
				bsfd_pkg::REG_ESCAPE_OFFSET: cfg_q.escape_offset <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The staged byte is decoded once the queue can absorb its worst case of
	// two results; the stage then frees and can take a new request that cycle.
	assign fire     = s1_valid_q && room2;
	assign s_tready = !s1_valid_q || room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_byte_s1  <= s_tdata;
			s1_chunk_s1 <= s_tlast;
		end
	end

	bsfd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.rx_byte   (s1_byte_s1),
		.chunk_end (s1_chunk_s1),
		.cfg       (cfg_q),
		.dout      (dec)
	);

	bsfd_outq #(
		.DEPTH (QDEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.din       (dec),
		.room2     (room2),
		.out_valid (q_valid),
		.out_ready (m_tready),
		.dout      (q_out)
	);

	assign m_tvalid = q_valid;
	assign m_tdata  = {7'd0, q_out.frame_good, q_out.payload};
	assign m_tuser  = q_out.item_kind;
	assign m_tlast  = q_out.last;

endmodule

@@ rtl/bsfd_decode.sv @@
// Deframing state and the per-byte decode. Next-state and result logic is
// combinational, up to an add and a compare deep; the state updates on fire.
module bsfd_decode (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           rx_byte,
	input  logic                 chunk_end,
	input  bsfd_pkg::cfg_t       cfg,
	output bsfd_pkg::decode_out_t dout
);

	logic       in_frame_q;
	logic       esc_q;
	logic       held_v_q;
	logic [7:0] held_q;
	logic [7:0] sum_q;

	logic       in_frame_n;
	logic       esc_n;
	logic       held_v_n;
	logic [7:0] held_n;
	logic [7:0] sum_n;

	logic       is_flag;
	logic       pay_emit;
	logic       end_emit;
	logic       end_good;
	logic       close_chunk;
	bsfd_pkg::result_t pay_res;
	bsfd_pkg::result_t end_res;

	always_comb begin
		in_frame_n = in_frame_q;
		esc_n      = esc_q;
		held_v_n   = held_v_q;
		held_n     = held_q;
		sum_n      = sum_q;
		pay_emit   = 1'b0;
		end_emit   = 1'b0;
		end_good   = 1'b0;
		close_chunk = 1'b0;
		is_flag    = (rx_byte == cfg.frame_flag);

		if (is_flag) begin
			if (in_frame_q && (held_v_q || esc_q)) begin
				end_emit = 1'b1;
				end_good = held_v_q && !esc_q && (held_q == sum_q);
			end
			in_frame_n = 1'b1;
			esc_n      = 1'b0;
			held_v_n   = 1'b0;
			held_n     = 8'd0;
			sum_n      = 8'd0;
		end else if (in_frame_q) begin
			if (esc_q) begin
				esc_n = 1'b0;
				if (held_v_q) begin
					pay_emit = 1'b1;
					sum_n    = sum_q + held_q;
				end
				held_n   = rx_byte + cfg.escape_offset;
				held_v_n = 1'b1;
			end else if (rx_byte == cfg.escape_code) begin
				esc_n = 1'b1;
			end else begin
				if (held_v_q) begin
					pay_emit = 1'b1;
					sum_n    = sum_q + held_q;
				end
				held_n   = rx_byte;
				held_v_n = 1'b1;
			end
			// Early close on a chunk boundary when the held byte already
			// matches the sum of everything before it.
			close_chunk = chunk_end && held_v_n && !esc_n && (held_n == sum_n);
			if (close_chunk) begin
				end_emit   = 1'b1;
				end_good   = 1'b1;
				in_frame_n = 1'b0;
				esc_n      = 1'b0;
				held_v_n   = 1'b0;
				held_n     = 8'd0;
				sum_n      = 8'd0;
			end
		end
	end

	always_comb begin
		pay_res.item_kind  = bsfd_pkg::KIND_PAYLOAD;
		pay_res.payload    = held_q;
		pay_res.frame_good = 1'b0;
		pay_res.last       = !end_emit;
		end_res.item_kind  = bsfd_pkg::KIND_FRAME_END;
		end_res.payload    = 8'd0;
		end_res.frame_good = end_good;
		end_res.last       = 1'b1;

		dout.count = {1'b0, pay_emit} + {1'b0, end_emit};
		dout.res0  = pay_emit ? pay_res : end_res;
		dout.res1  = end_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			held_v_q   <= 1'b0;
			held_q     <= 8'd0;
			sum_q      <= 8'd0;
		end else if (fire) begin
			in_frame_q <= in_frame_n;
			esc_q      <= esc_n;
			held_v_q   <= held_v_n;
			held_q     <= held_n;
			sum_q      <= sum_n;
		end
	end

endmodule

@@ rtl/bsfd_outq.sv @@
// Result queue: takes up to two results a cycle; pops one on out_ready.
module bsfd_outq #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bsfd_pkg::decode_out_t din,
	output logic                  room2,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bsfd_pkg::result_t     dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bsfd_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] wr_p1;
	logic [PW-1:0] wr_p2;
	logic [PW-1:0] rd_p1;
	logic          pop;
	logic [1:0]    n_in;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		logic [PW-1:0] r;
		if (p == PW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PW'(1);
		end
		return r;
	endfunction

	assign wr_p1     = ptr_inc(wr_q);
	assign wr_p2     = ptr_inc(wr_p1);
	assign rd_p1     = ptr_inc(rd_q);
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_q];
	assign n_in      = push ? din.count : 2'd0;
	// Room for a full two-result write, counting a slot freed this cycle.
	assign room2     = ({1'b0, cnt_q} + (CW + 1)'(2)) <=
		((CW + 1)'(DEPTH) + {{CW{1'b0}}, pop});

	always_ff @(posedge clk) begin
		if (n_in != 2'd0) begin
			mem_q[wr_q] <= din.res0;
		end
		if (n_in == 2'd2) begin
			mem_q[wr_p1] <= din.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (n_in)
				2'd1: wr_q <= wr_p1;
				2'd2: wr_q <= wr_p2;
				default: wr_q <= wr_q;
			endcase
			if (pop) begin
				rd_q <= rd_p1;
			end
			cnt_q <= cnt_q + CW'(n_in) - CW'(pop);
		end
	end

endmodule

@@ sim/tb_top.sv @@
module tb_top;

	// Hard stop for a hung run. The slowest correct run is roughly 1000 bytes, each
	// waiting out a sender gap and giving up to two results that each wait out a
	// receiver stall. The limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 300000;

	// Number of random bytes aimed at per phase, not counting noise bytes.
	localparam int PHASE_BYTES = 140;

	// One byte request as the driver puts it on the input stream. When
	// drain_first is set, the driver holds this request back until every
	// result predicted so far has come out of the block.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       chunk_end;
		logic       drain_first;
	} line_req_t;

	logic        clk;
	logic        arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_tlast = 1'b0;    // chunk_end

	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] payload, [8] frame_good, [15:9] zero
	logic        m_tuser;           // item_kind
	logic        m_tlast;           // last result of one input byte

	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = bsfd_pkg::REG_FRAME_FLAG;
	logic [7:0]  cfg_data = 8'h00;

	byte_stuff_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Byte requests waiting to be driven, and results that the decoder model
	// says must still come out, oldest first.
	line_req_t         byte_req_q[$];
	bsfd_pkg::result_t frame_result_q[$];

	// Idle knobs in percent, changed only at a rising edge between phases.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	int  mismatches = 0;
	int  results_seen = 0;
	int  noise_bytes = 0;
	int  cycle_count = 0;
	logic req_taken = 1'b0;

	// Mirror of the decoder: register copy plus the deframer state.
	bsfd_pkg::cfg_t cfg_model;
	logic       dec_in_frame;
	logic       dec_esc_pending;
	logic       dec_held_valid;
	logic [7:0] dec_held_byte;
	logic [7:0] dec_sum;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a run that does not finish in time counts as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("result %0d: %s: got 0x%0h, expected 0x%0h", results_seen, what,
			got, want);
		mismatches++;
	endtask

	task automatic clear_frame_state();
		dec_esc_pending = 1'b0;
		dec_held_valid = 1'b0;
		dec_held_byte = 8'h00;
		dec_sum = 8'h00;
	endtask

	// Runs one accepted byte through the deframer mirror and queues the results
	// it causes: at most a released payload byte followed by a frame end.
	task automatic decode_byte(input logic [7:0] b, input logic ce);
		bsfd_pkg::result_t res [2];
		int         n;
		logic [7:0] v;
		logic       have;
		logic       good;
		n = 0;
		v = 8'h00;
		if (b == cfg_model.frame_flag) begin
			// A flag always closes or opens, even right after an escape. A frame
			// with nothing held and no escape pending closes silently.
			if (dec_in_frame && (dec_held_valid || dec_esc_pending)) begin
				good = dec_held_valid && !dec_esc_pending && dec_held_byte == dec_sum;
				res[n] = '{bsfd_pkg::KIND_FRAME_END, 8'h00, good, 1'b0};
				n++;
			end
			dec_in_frame = 1'b1;
			clear_frame_state();
		end else if (dec_in_frame) begin
			have = 1'b1;
			if (dec_esc_pending) begin
				v = b + cfg_model.escape_offset;
				dec_esc_pending = 1'b0;
			end else if (b == cfg_model.escape_code) begin
				dec_esc_pending = 1'b1;
				have = 1'b0;
			end else begin
				v = b;
			end
			// The byte held back so far is released as payload and summed; the
			// new byte takes its place as the checksum candidate.
			if (have) begin
				if (dec_held_valid) begin
					res[n] = '{bsfd_pkg::KIND_PAYLOAD, dec_held_byte, 1'b0, 1'b0};
					n++;
					dec_sum = dec_sum + dec_held_byte;
				end
				dec_held_byte = v;
				dec_held_valid = 1'b1;
			end
			// Early close at a chunk end, only on a checksum match.
			if (ce && dec_held_valid && !dec_esc_pending && dec_held_byte == dec_sum) begin
				res[n] = '{bsfd_pkg::KIND_FRAME_END, 8'h00, 1'b1, 1'b0};
				n++;
				dec_in_frame = 1'b0;
				clear_frame_state();
			end
		end
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			frame_result_q.push_back(res[i]);
	endtask

	// Input side: a new request goes out at the falling edge once the previous
	// one has been taken, unless the sender idles or a drain is requested.
	always @(negedge clk) begin : drive
		line_req_t req;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (!s_tvalid || req_taken) begin
				if (byte_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						!(byte_req_q[0].drain_first && frame_result_q.size() != 0)) begin
					req = byte_req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= req.rx_byte;
					s_tlast <= req.chunk_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Both handshakes are sampled at the rising edge. An accepted byte is
	// predicted at once, so its results are queued long before they can appear.
	always @(posedge clk) begin : watch
		bsfd_pkg::result_t want;
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (frame_result_q.size() == 0) begin
					report_mismatch("result with nothing expected", m_tdata, 16'h0000);
				end else begin
					want = frame_result_q.pop_front();
					if (m_tuser !== want.item_kind)
						report_mismatch("item_kind", m_tuser, want.item_kind);
					if (m_tdata[7:0] !== want.payload)
						report_mismatch("payload", m_tdata[7:0], want.payload);
					if (m_tdata[8] !== want.frame_good)
						report_mismatch("frame_good", m_tdata[8], want.frame_good);
					if (m_tlast !== want.last)
						report_mismatch("last", m_tlast, want.last);
					if (m_tdata[15:9] !== 7'd0)
						report_mismatch("tdata padding", m_tdata[15:9], 16'h0000);
				end
				results_seen++;
			end
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic ce, input logic drain);
		byte_req_q.push_back(line_req_t'{b, ce, drain});
	endtask

	// Puts one payload byte on the line, stuffed where it would otherwise read
	// as a flag or escape, and now and then stuffed for no reason. When flag and
	// escape share one value no stuffing can work, so the byte goes out raw.
	task automatic queue_coded(input logic [7:0] v, input logic ce);
		logic stuff;
		stuff = (cfg_model.frame_flag != cfg_model.escape_code) &&
			(v == cfg_model.frame_flag || v == cfg_model.escape_code ||
			$urandom_range(7) == 0);
		if (stuff) begin
			queue_byte(cfg_model.escape_code, 1'b0, 1'b0);
			queue_byte(v - cfg_model.escape_offset, ce, 1'b0);
		end else begin
			queue_byte(v, ce, 1'b0);
		end
	endtask

	// One frame under the current registers: an opening flag, a short payload
	// (rarely a longer one), a checksum that is sometimes corrupted, and an
	// ending that is a chunk end, the next frame's flag, or a dangling escape.
	task automatic queue_frame(input logic drain);
		int         len;
		int         ending;
		logic [7:0] v;
		logic [7:0] sum;
		queue_byte(cfg_model.frame_flag, 1'($urandom_range(1)), drain);
		len = ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(6);
		sum = 8'h00;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: v = cfg_model.frame_flag;
				1: v = cfg_model.escape_code;
				2: v = 8'h00;
				3: v = 8'hFF;
				default: v = 8'($urandom);
			endcase
			queue_coded(v, $urandom_range(15) == 0);
			sum = sum + v;
		end
		if ($urandom_range(4) == 0)
			sum = sum ^ (8'h01 << $urandom_range(7));
		ending = $urandom_range(3);
		queue_coded(sum, ending < 2);
		if (ending == 3)
			queue_byte(cfg_model.escape_code, 1'b0, 1'b0);
	endtask

	// Line garbage: arbitrary bytes with arbitrary chunk ends.
	task automatic queue_noise();
		int n;
		n = $urandom_range(4, 1);
		for (int i = 0; i < n; i++)
			queue_byte(8'($urandom), 1'($urandom_range(1)), 1'b0);
		noise_bytes += n;
	endtask

	// Registers are written at the falling edge and taken at the next rising
	// edge; the mirror copy changes with them while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			bsfd_pkg::REG_FRAME_FLAG:    cfg_model.frame_flag = value;
			bsfd_pkg::REG_ESCAPE_CODE:   cfg_model.escape_code = value;
			bsfd_pkg::REG_ESCAPE_OFFSET: cfg_model.escape_offset = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every request is out, the last one has been taken and every
	// predicted result has arrived, then lets a byte that causes no result pass
	// through the input stage, the decode state and the result queue. The check runs at the
	// rising edge, where the request queue and the input handshake are settled.
	task automatic wait_idle();
		@(posedge clk);
		while (byte_req_q.size() != 0 || s_tvalid || frame_result_q.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	initial begin : stimulus
		logic first;
		cfg_model = '{bsfd_pkg::FRAME_FLAG_RST, bsfd_pkg::ESCAPE_CODE_RST,
			bsfd_pkg::ESCAPE_OFFSET_RST};
		dec_in_frame = 1'b0;
		clear_frame_state();

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset registers: flag 0x7D, escape 0x7E,
		// offset 0x20. No idling, so each case passes through back to back.
		@(posedge clk);
		queue_byte(8'h00, 1'b0, 1'b0);  // outside a frame: ignored
		queue_byte(8'hFF, 1'b1, 1'b0);  // ignored, chunk end too
		queue_byte(8'h7D, 1'b0, 1'b0);  // opens a frame
		queue_byte(8'h7D, 1'b0, 1'b0);  // empty frame: no result
		queue_byte(8'h01, 1'b0, 1'b0);
		queue_byte(8'h02, 1'b0, 1'b0);  // releases 0x01
		queue_byte(8'h03, 1'b1, 1'b0);  // releases 0x02, checksum matches at chunk end
		queue_byte(8'h55, 1'b0, 1'b0);  // decoder now waits for a flag: ignored
		queue_byte(8'h7D, 1'b0, 1'b0);
		queue_byte(8'h7E, 1'b1, 1'b0);  // chunk end with an escape pending: nothing
		queue_byte(8'h5D, 1'b0, 1'b0);  // escaped, counts as 0x7D
		queue_byte(8'h7E, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);  // escaped with wrap-around to 0x1F
		queue_byte(8'h7D, 1'b0, 1'b0);  // flag closes with a wrong checksum
		queue_byte(8'h7E, 1'b0, 1'b0);
		queue_byte(8'h7D, 1'b0, 1'b0);  // flag meets a dangling escape: bad end
		queue_byte(8'h10, 1'b1, 1'b0);  // chunk end without a match: no close
		queue_byte(8'h10, 1'b1, 1'b0);  // sum 0x10 matches: early good close
		queue_byte(8'h7D, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0);
		queue_byte(8'h7E, 1'b0, 1'b0);
		queue_byte(8'hDF, 1'b0, 1'b0);  // escaped to 0xFF
		queue_byte(8'h7D, 1'b0, 1'b0);  // flag closes with a good checksum

		// Random phases, each under its own registers and idling pattern.
		for (int phase = 1; phase <= 6; phase++) begin
			wait_idle();
			case (phase)
				1: begin
					write_reg(bsfd_pkg::REG_FRAME_FLAG, 8'h00);
					write_reg(bsfd_pkg::REG_ESCAPE_CODE, 8'hFF);
					write_reg(bsfd_pkg::REG_ESCAPE_OFFSET, 8'hFF);
				end
				2: begin
					write_reg(bsfd_pkg::REG_FRAME_FLAG, 8'hFF);
					write_reg(bsfd_pkg::REG_ESCAPE_CODE, 8'h00);
					write_reg(bsfd_pkg::REG_ESCAPE_OFFSET, 8'h00);
				end
				3: begin
					// Flag and escape share a value, so the flag test always wins.
					write_reg(bsfd_pkg::REG_FRAME_FLAG, 8'h55);
					write_reg(bsfd_pkg::REG_ESCAPE_CODE, 8'h55);
					write_reg(bsfd_pkg::REG_ESCAPE_OFFSET, 8'h01);
				end
				4: begin
					write_reg(bsfd_pkg::REG_FRAME_FLAG, bsfd_pkg::FRAME_FLAG_RST);
					write_reg(bsfd_pkg::REG_ESCAPE_CODE, bsfd_pkg::ESCAPE_CODE_RST);
					write_reg(bsfd_pkg::REG_ESCAPE_OFFSET, bsfd_pkg::ESCAPE_OFFSET_RST);
				end
				default: begin
					write_reg(bsfd_pkg::REG_FRAME_FLAG, 8'($urandom));
					write_reg(bsfd_pkg::REG_ESCAPE_CODE, 8'($urandom));
					write_reg(bsfd_pkg::REG_ESCAPE_OFFSET, 8'($urandom));
				end
			endcase

			// Knobs and the request queue change at a rising edge, away from the
			// falling edge at which the driver reads them.
			@(posedge clk);
			case (phase)
				1, 5: begin
					send_idle_pct = 88;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 88;
				end
				3, 6: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase

			// Mostly well-formed frames with random content; some noise. The first
			// frame of each phase, and a few more, wait for the block to drain.
			noise_bytes = 0;
			first = 1'b1;
			while (byte_req_q.size() - noise_bytes < PHASE_BYTES) begin
				if ($urandom_range(6) == 0) begin
					queue_noise();
				end else begin
					queue_frame(first || $urandom_range(39) == 0);
					first = 1'b0;
				end
			end
		end

		wait_idle();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
